[rtl/sha_pkg.sv]
// Package with the SHA-256 round constants, initial hash values and types.
package sha_pkg;
	localparam int BLOCK_BYTES = 64;
	localparam int PAD_LIMIT = 56;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [31:0] word_t;

	localparam word_t INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	// Commands from the controller to the compression core.
	typedef struct packed {
		logic start;
	} core_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	function automatic word_t ror(input word_t x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction
endpackage

[rtl/sha_core.sv]
// SHA-256 compression core: one round per cycle, chaining words in a small memory.
module sha_core
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  core_cmd_t   cmd,
	output core_sts_t   sts,
	// Message word fetch from the block buffer, registered read data.
	output logic [3:0]  msg_addr,
	input  word_t       msg_word,
	// Chaining word reset and readout.
	input  logic        chain_init,
	input  logic [2:0]  rd_idx,
	output word_t       rd_word
);
	typedef enum logic [3:0] {
		C_IDLE = 4'b0001, C_LOAD = 4'b0010, C_ROUND = 4'b0100, C_ADD = 4'b1000
	} cstate_t;

	cstate_t state_q;
	logic [5:0] cnt_q;
	logic  done_q;
	word_t a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	word_t w_q [16];
	word_t chain_q [8];
	logic  chain_vld_q;
	word_t wt, s0, s1, ch, mj, t1, t2, wnew;
	logic [5:0] rnd;

	function automatic word_t rd_word_f(input int i);
		rd_word_f = chain_vld_q ? chain_q[i] : INIT_HASH[i];
	endfunction

	assign rnd = cnt_q;
	// The fetch runs one word ahead of the round that consumes it.
	assign msg_addr = (state_q == C_ROUND) ? cnt_q[3:0] + 4'd1 : cnt_q[3:0];
	assign sts = '{busy: (state_q != C_IDLE), done: done_q};
	assign rd_word = chain_vld_q ? chain_q[rd_idx] : INIT_HASH[rd_idx];

	always_comb begin
		wnew = w_q[0] + (ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3))
			+ w_q[9] + (ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10));
		wt = (rnd < 6'd16) ? msg_word : wnew;
		s1 = ror(e_q, 6) ^ ror(e_q, 11) ^ ror(e_q, 25);
		ch = (e_q & f_q) ^ (~e_q & g_q);
		t1 = h_q + s1 + ch + ROUND_K[rnd] + wt;
		s0 = ror(a_q, 2) ^ ror(a_q, 13) ^ ror(a_q, 22);
		mj = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
		t2 = s0 + mj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
			chain_vld_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (chain_init) chain_vld_q <= 1'b0;
			case (state_q)
				C_IDLE: if (cmd.start) begin
					state_q <= C_LOAD;
					cnt_q <= '0;
				end
				C_LOAD: state_q <= C_ROUND;
				C_ROUND: begin
					if (cnt_q == 6'd63) begin
						state_q <= C_ADD;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				C_ADD: begin
					state_q <= C_IDLE;
					done_q <= 1'b1;
					chain_vld_q <= 1'b1;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && cmd.start) begin
			{a_q, b_q, c_q, d_q} <= {rd_word_f(0), rd_word_f(1), rd_word_f(2), rd_word_f(3)};
			{e_q, f_q, g_q, h_q} <= {rd_word_f(4), rd_word_f(5), rd_word_f(6), rd_word_f(7)};
		end
		if (state_q == C_ROUND) begin
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
		end
		if (state_q == C_ADD) begin
			chain_q[0] <= rd_word_f(0) + a_q; chain_q[1] <= rd_word_f(1) + b_q;
			chain_q[2] <= rd_word_f(2) + c_q; chain_q[3] <= rd_word_f(3) + d_q;
			chain_q[4] <= rd_word_f(4) + e_q; chain_q[5] <= rd_word_f(5) + f_q;
			chain_q[6] <= rd_word_f(6) + g_q; chain_q[7] <= rd_word_f(7) + h_q;
		end
	end
endmodule

[rtl/sha256_stream_hasher.sv]
// Top level of the SHA-256 stream hasher.
// Each s_axis transaction carries one message byte (tuser = 0) or a finish
// request (tuser = 1). Bytes are written into a 64-byte block memory, four
// bytes per 32-bit word; when a block fills, the compression core runs 64
// rounds, one per cycle, reading message words from that memory, and no
// further transaction is taken until that block has been compressed. A finish
// writes the 0x80 pad, zeros and the big-endian bit count one byte per cycle
// (the count goes into a second block when the pad leaves no room for it),
// compresses each padded block, and then sends the digest as eight m_axis
// transactions, word 0 first, with tlast on word 7. No input is taken after
// the finish until the last digest word has been accepted. The hash then
// returns to its initial values for the next message.
module sha256_stream_hasher
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_axis_tlast   // last_word
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001, S_PAD = 5'b00010, S_HASH = 5'b00100,
		S_WAIT = 5'b01000, S_OUT = 5'b10000
	} state_t;

	state_t state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic        final_q;   // the block being hashed ends the message
	logic [2:0]  oidx_q;
	logic [31:0] mem_q [16];   // block buffer, big-endian bytes in words
	logic [31:0] mem_rd_q;
	logic        wr_en;
	logic [5:0]  wr_addr;
	logic [7:0]  wr_byte;
	logic        padding;
	logic        padding_pending_q;
	core_cmd_t   cmd;
	core_sts_t   sts;
	logic [3:0]  msg_addr;
	logic        chain_init;
	word_t       rd_word;

	sha_core u_core (
		.clk, .arst_n, .cmd, .sts, .msg_addr, .msg_word(mem_rd_q),
		.chain_init, .rd_idx(oidx_q), .rd_word
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata = {5'd0, oidx_q, rd_word};
	assign m_axis_tlast = (oidx_q == 3'd7);
	assign chain_init = m_axis_tvalid && m_axis_tready && m_axis_tlast;

	// Byte for the current fill position: the data byte, the 0x80 pad on a finish, or zeros and the count while padding.
	always_comb begin
		padding = (state_q == S_PAD);
		wr_addr = fill_q;
		if (padding && fill_q >= 6'(PAD_LIMIT) && final_q)
			wr_byte = bits_q[8*(7 - fill_q[2:0]) +: 8];
		else if (padding)
			wr_byte = 8'h00;
		else if (s_axis_tuser)
			wr_byte = PAD_BYTE;
		else
			wr_byte = s_axis_tdata;
		wr_en = padding || (s_axis_tvalid && s_axis_tready);
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr[5:2]][8*(3 - wr_addr[1:0]) +: 8] <= wr_byte;
		mem_rd_q <= mem_q[msg_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			final_q <= 1'b0;
			oidx_q <= '0;
			cmd.start <= 1'b0;
		end else begin
			cmd.start <= 1'b0;
			case (state_q)
				S_IDLE: if (s_axis_tvalid) begin
					fill_q <= fill_q + 6'd1;
					if (!s_axis_tuser) begin
						bits_q <= bits_q + 64'd8;
						final_q <= 1'b0;
						if (fill_q == 6'd63) begin
							state_q <= S_HASH;
							cmd.start <= 1'b1;
						end
					end else begin
						// The count goes in this block only if the pad byte left room.
						final_q <= (fill_q < 6'(PAD_LIMIT));
						if (fill_q == 6'd63) begin
							state_q <= S_HASH;
							cmd.start <= 1'b1;
						end else begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						state_q <= S_HASH;
						cmd.start <= 1'b1;
					end
				end
				S_HASH: state_q <= S_WAIT;
				S_WAIT: if (sts.done) begin
					if (final_q) begin
						state_q <= S_OUT;
						oidx_q <= '0;
					end else if (bits_q[0] == 1'b0 && padding_pending_q) begin
						state_q <= S_PAD;
						final_q <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: if (m_axis_tready) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						state_q <= S_IDLE;
						bits_q <= '0;
						fill_q <= '0;
						final_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Set when a finish is accepted, cleared while the digest is sent out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			padding_pending_q <= 1'b0;
		else if (state_q == S_IDLE && s_axis_tvalid && s_axis_tuser)
			padding_pending_q <= 1'b1;
		else if (state_q == S_OUT)
			padding_pending_q <= 1'b0;
	end
endmodule

[verif/tb_top.sv]
// Testbench for the SHA-256 stream hasher: random and directed messages checked against a local hash model.
module tb_top
	import sha_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_FINISH = 1'b1;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       last_word;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;  // [7:0] data_byte
	logic        s_axis_tuser = 1'b0;  // [0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;  // [31:0] digest_word, [34:32] word_index, rest zero
	logic        m_axis_tlast;  // last_word

	sha256_stream_hasher uut (.*);

	always #5 clk = ~clk;

	// Local hash state, advanced when each input transaction is accepted.
	word_t       hash_state [8];
	logic [63:0] bit_total;
	logic [7:0]  msg_block [64];
	int unsigned block_fill;

	digest_beat_t digest_queue [$];
	int unsigned  error_count = 0;
	int unsigned  idle_cycles = 0;
	bit           hold_ready = 1'b0;
	bit           bursty_ready = 1'b1;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void hash_reset();
		for (int i = 0; i < 8; i++) hash_state[i] = INIT_HASH[i];
		bit_total = '0;
		block_fill = 0;
	endfunction

	// One 64-round compression of msg_block into hash_state.
	function automatic void compress_block();
		word_t w [64];
		word_t v [8];
		word_t t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = w[t-16] + w[t-7]
				+ (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
				+ (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endfunction

	// Apply one accepted transaction; a finish queues the eight digest words.
	function automatic void hash_accept(input logic kind, input logic [7:0] data);
		if (kind == KIND_DATA) begin
			msg_block[block_fill] = data;
			bit_total += 64'd8;
			block_fill++;
			if (block_fill == BLOCK_BYTES) begin
				compress_block();
				block_fill = 0;
			end
			return;
		end
		msg_block[block_fill++] = PAD_BYTE;
		// No room for the length: pad out this block and use a second one.
		if (block_fill > PAD_LIMIT) begin
			while (block_fill < BLOCK_BYTES) msg_block[block_fill++] = 8'h00;
			compress_block();
			block_fill = 0;
		end
		while (block_fill < PAD_LIMIT) msg_block[block_fill++] = 8'h00;
		for (int i = 0; i < 8; i++) msg_block[PAD_LIMIT + i] = bit_total[8*(7-i) +: 8];
		compress_block();
		for (int i = 0; i < 8; i++)
			digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
		hash_reset();
	endfunction

	// Offer one transaction after a random gap, then wait until it is accepted.
	task automatic send_item(input logic kind, input logic [7:0] data);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) @(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = kind;
		s_axis_tdata = data;
		do @(posedge clk); while (!s_axis_tready);
		hash_accept(kind, data);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) send_item(KIND_DATA, 8'($urandom));
		send_item(KIND_FINISH, 8'($urandom));
	endtask

	task automatic wait_drained();
		while (digest_queue.size() != 0) @(negedge clk);
	endtask

	// Result checking at the rising edge.
	always @(posedge clk) begin
		digest_beat_t exp_beat;
		if (m_axis_tvalid && m_axis_tready) begin
			if (digest_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected digest word %h", m_axis_tdata));
			end else begin
				exp_beat = digest_queue.pop_front();
				if (m_axis_tdata[31:0] !== exp_beat.digest_word)
					report_mismatch($sformatf("word %0d: got %h, want %h", exp_beat.word_index,
						m_axis_tdata[31:0], exp_beat.digest_word));
				if (m_axis_tdata[34:32] !== exp_beat.word_index)
					report_mismatch($sformatf("word_index got %0d, want %0d",
						m_axis_tdata[34:32], exp_beat.word_index));
				if (m_axis_tlast !== exp_beat.last_word)
					report_mismatch($sformatf("tlast got %b on word %0d", m_axis_tlast,
						exp_beat.word_index));
				if (m_axis_tdata[39:35] !== '0)
					report_mismatch("tdata padding bits not zero");
			end
		end
	end

	// Receiver readiness: random stalls unless a long hold-off is in force; always ready when bursty_ready is off.
	always @(negedge clk) begin
		if (hold_ready)
			m_axis_tready <= 1'b0;
		else if (!bursty_ready)
			m_axis_tready <= 1'b1;
		else if ($urandom_range(0, 19) == 0)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 3) != 0);
	end

	// Watchdog: cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Known vectors: the empty message, "abc" and a four-byte message.
	task automatic test_directed();
		send_item(KIND_FINISH, 8'hff);
		send_item(KIND_DATA, 8'h61);
		send_item(KIND_DATA, 8'h62);
		send_item(KIND_DATA, 8'h63);
		send_item(KIND_FINISH, 8'h00);
		send_item(KIND_DATA, 8'h00);
		send_item(KIND_DATA, 8'hff);
		send_item(KIND_DATA, 8'h55);
		send_item(KIND_DATA, 8'haa);
		send_item(KIND_FINISH, 8'h00);
	endtask

	// Lengths around the one-block and two-block padding cases.
	task automatic test_pad_boundaries();
		int lens [3] = '{55, 56, 63};
		foreach (lens[i]) send_message(lens[i]);
	endtask

	// The receiver holds off long enough for the block to stall its input, then stays ready for one message.
	task automatic test_backpressure();
		fork
			begin
				hold_ready = 1'b1;
				repeat (600) @(negedge clk);
				hold_ready = 1'b0;
			end
			begin
				send_message(3);
				send_message(5);
				send_message(2);
			end
		join
		wait_drained();
		bursty_ready = 1'b0;
		send_message(8);
		wait_drained();
		bursty_ready = 1'b1;
	endtask

	// Random messages, mostly short, a few spanning more than one block.
	task automatic test_random();
		int sent;
		int len;
		sent = 0;
		while (sent < 90) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(57, 72)
				: $urandom_range(0, 20);
			send_message(len);
			sent += len + 1;
			if ($urandom_range(0, 4) == 0) wait_drained();
		end
	endtask

	initial begin
		hash_reset();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_pad_boundaries();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (100) @(negedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

[sha256_stream_hasher.f]
rtl/sha_pkg.sv
rtl/sha_core.sv
rtl/sha256_stream_hasher.sv
verif/tb_top.sv
